// ===== rtl/core/mbps_pkg.sv =====
// ---------------------------------------------------------------------------
// mbps_pkg: metaball pixel shader shared definitions
// Widths, codes and the item record passed from the front end to the engine.
// ---------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

   localparam int NUM_BALLS  = 5;
   localparam int COORD_BITS = 10;
   localparam int BALL_BITS  = (NUM_BALLS > 1) ? $clog2(NUM_BALLS) : 1;

   localparam int X_BITS     = COORD_BITS + 2;
   localparam int Y_BITS     = COORD_BITS + 1;
   localparam int PY_BITS    = COORD_BITS - 1;
   localparam int IDX_BITS   = 3;
   localparam int SPEED_BITS = 6;
   localparam int CHAN_BITS  = 8;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = COORD_BITS;

   localparam int WIDTH_RESET  = 800;
   localparam int HEIGHT_RESET = 450;
   localparam int SPEED_RESET  = 20;
   localparam int CHAN_MAX     = 255;

   // squared distance datapath
   localparam int DX_BITS = X_BITS + 1;
   localparam int SQ_BITS = 2 * (DX_BITS - 1);
   localparam int D2_BITS = SQ_BITS + 1;

   // 2550^2: full scale of one ball's contribution, squared
   localparam int FULL_SCALE_SQ = 6502500;
   localparam int KBITS     = $clog2(FULL_SCALE_SQ + 1);
   localparam int SQ_STEPS  = (KBITS + 1) / 2;
   localparam int RT_BITS   = 2 * SQ_STEPS;
   localparam int C_BITS    = SQ_STEPS;
   localparam int ACC_BITS  = C_BITS + 1;
   localparam int STEP_BITS = $clog2(KBITS);

   localparam int FIFO_DEPTH = 2;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_FRAME = 2'd1,
      REQ_PIXEL = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      COL_RED     = 2'd0,
      COL_GREEN   = 2'd1,
      COL_BLUE    = 2'd2,
      COL_MAGENTA = 2'd3
   } color_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_BALL_SPEED   = 2'd2
   } csr_addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOVE,
      ST_DIST,
      ST_SUM,
      ST_DIV,
      ST_SQRT,
      ST_ACC,
      ST_OUT
   } eng_state_type;

   typedef struct packed {
      req_kind_type            kind;
      logic [BALL_BITS-1:0]    ball;
      logic [COORD_BITS-1:0]   x;
      logic [PY_BITS-1:0]      y;
      color_type               color;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/mbps_if.sv =====
// ---------------------------------------------------------------------------
// mbps channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface mbps_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       req_type;
   logic [mbps_pkg::IDX_BITS-1:0]    ball_index;
   logic [mbps_pkg::COORD_BITS-1:0]  pos_x;
   logic [mbps_pkg::PY_BITS-1:0]     pos_y;
   logic [1:0]                       color_code;

   modport source (output valid, req_type, ball_index, pos_x, pos_y, color_code,
                   input ready);
   modport sink   (input valid, req_type, ball_index, pos_x, pos_y, color_code,
                   output ready);
endinterface

interface mbps_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mbps_pkg::CHAN_BITS-1:0]  red;
   logic [mbps_pkg::CHAN_BITS-1:0]  green;
   logic [mbps_pkg::CHAN_BITS-1:0]  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface mbps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mbps_pkg::CSR_ADDR_BITS-1:0]  addr;
   logic [mbps_pkg::CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/metaball_pixel_shader.sv =====
// ---------------------------------------------------------------------------
// metaball_pixel_shader: metaball renderer core
// Five bouncing balls; pixel requests return a saturated RGB intensity.
// ---------------------------------------------------------------------------
//  channel | direction | carries
//  req_bus | in        | req_type, ball_index, pos_x, pos_y, color_code
//  rsp_bus | out       | red, green, blue (pixel requests only)
//  csr_bus | in        | addr, wdata (0 width, 1 height, 2 speed)
//
//  Load: written in the engine's idle state. Frame: moves each ball in turn.
//  Pixel: distance and sum, then the shared 23-step divider
//  and 12-step square root that each ball passes through in turn.
//  A two-entry queue keeps requests flowing while the engine or rsp stalls.
//  Synchronous reset clears balls to zero and registers to 800/450/20.
// ---------------------------------------------------------------------------
`default_nettype none

module metaball_pixel_shader (
   input  logic          clock,
   input  logic          reset,
   mbps_req_if.sink      req_bus,
   mbps_rsp_if.source    rsp_bus,
   mbps_csr_if.sink      csr_bus
);

   mbps_pkg::op_type         push_op, pop_op;
   mbps_pkg::fifo_stat_type  fifo_stat;
   logic                     push, pop;

   mbps_front u_front (
      .req_bus   (req_bus),
      .fifo_stat (fifo_stat),
      .push      (push),
      .push_op   (push_op)
   );

   mbps_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .pop_op  (pop_op),
      .stat    (fifo_stat)
   );

   mbps_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_bus   (csr_bus),
      .rsp_bus   (rsp_bus),
      .pop_op    (pop_op),
      .fifo_stat (fifo_stat),
      .pop       (pop)
   );

endmodule

`default_nettype wire

// ===== rtl/core/mbps_front.sv =====
// ---------------------------------------------------------------------------
// mbps_front: request intake
// Accepts requests, drops the ones with no effect and queues the rest.
// ---------------------------------------------------------------------------
`default_nettype none

module mbps_front (
   mbps_req_if.sink                  req_bus,
   input  mbps_pkg::fifo_stat_type   fifo_stat,
   output logic                      push,
   output mbps_pkg::op_type          push_op
);

   logic idx_ok;

   assign req_bus.ready = !fifo_stat.full;
   assign idx_ok = 32'(req_bus.ball_index) < mbps_pkg::NUM_BALLS;

   always_comb begin
      push_op.kind  = mbps_pkg::req_kind_type'(req_bus.req_type);
      push_op.ball  = mbps_pkg::BALL_BITS'(req_bus.ball_index);
      push_op.x     = req_bus.pos_x;
      push_op.y     = req_bus.pos_y;
      push_op.color = mbps_pkg::color_type'(req_bus.color_code);
   end

   // request type 3 and loads to a missing ball are swallowed here
   always_comb begin
      push = 1'b0;
      if (req_bus.valid && !fifo_stat.full) begin
         unique case (req_bus.req_type)
            mbps_pkg::REQ_LOAD:  push = idx_ok;
            mbps_pkg::REQ_FRAME: push = 1'b1;
            mbps_pkg::REQ_PIXEL: push = 1'b1;
            default:             push = 1'b0;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mbps_fifo.sv =====
// ---------------------------------------------------------------------------
// mbps_fifo: decoupling queue
// Short register queue between the front end and the engine.
// ---------------------------------------------------------------------------
`default_nettype none

module mbps_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mbps_pkg::op_type          push_op,
   input  logic                      pop,
   output mbps_pkg::op_type          pop_op,
   output mbps_pkg::fifo_stat_type   stat
);

   localparam int PTR_BITS = (mbps_pkg::FIFO_DEPTH > 1) ? $clog2(mbps_pkg::FIFO_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(mbps_pkg::FIFO_DEPTH + 1);

   mbps_pkg::op_type        mem_ff [mbps_pkg::FIFO_DEPTH];
   logic [PTR_BITS-1:0]     wr_ff, wr_in;
   logic [PTR_BITS-1:0]     rd_ff, rd_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign stat.full  = cnt_ff == CNT_BITS'(mbps_pkg::FIFO_DEPTH);
   assign stat.empty = cnt_ff == '0;
   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;
   assign pop_op  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_BITS'(mbps_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_BITS'(mbps_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mbps_engine.sv =====
// ---------------------------------------------------------------------------
// mbps_engine: ball state and shading sequencer
// Holds the balls and registers, moves balls on frames and shades pixels
// one ball at a time with a restoring divider and a bitwise square root.
// ---------------------------------------------------------------------------
`default_nettype none

module mbps_engine (
   input  logic                      clock,
   input  logic                      reset,
   mbps_csr_if.sink                  csr_bus,
   mbps_rsp_if.source                rsp_bus,
   input  mbps_pkg::op_type          pop_op,
   input  mbps_pkg::fifo_stat_type   fifo_stat,
   output logic                      pop
);

   localparam int NB = mbps_pkg::NUM_BALLS;
   localparam int BB = mbps_pkg::BALL_BITS;
   localparam int XB = mbps_pkg::X_BITS;
   localparam int YB = mbps_pkg::Y_BITS;
   localparam int CB = mbps_pkg::CHAN_BITS;
   localparam int SB = mbps_pkg::STEP_BITS;
   localparam logic [mbps_pkg::RT_BITS-1:0] SBIT_INIT =
      mbps_pkg::RT_BITS'(1) << (2 * (mbps_pkg::SQ_STEPS - 1));

   function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a,
                                             input logic [mbps_pkg::C_BITS-1:0] c);
      logic [mbps_pkg::ACC_BITS-1:0] s;
      s = mbps_pkg::ACC_BITS'(a) + mbps_pkg::ACC_BITS'(c);
      return (s > mbps_pkg::ACC_BITS'(mbps_pkg::CHAN_MAX)) ? CB'(mbps_pkg::CHAN_MAX)
                                                          : s[CB-1:0];
   endfunction

   // registers
   logic [mbps_pkg::COORD_BITS-1:0] width_ff, width_in;
   logic [mbps_pkg::PY_BITS-1:0]    height_ff, height_in;
   logic [mbps_pkg::SPEED_BITS-1:0] speed_ff, speed_in;

   // ball state
   logic [XB-1:0]         bx_ff [NB];
   logic [XB-1:0]         bx_in [NB];
   logic [YB-1:0]         by_ff [NB];
   logic [YB-1:0]         by_in [NB];
   logic                  bdx_ff [NB];
   logic                  bdx_in [NB];
   logic                  bdy_ff [NB];
   logic                  bdy_in [NB];
   mbps_pkg::color_type   bcol_ff [NB];
   mbps_pkg::color_type   bcol_in [NB];

   mbps_pkg::eng_state_type state_ff, state_in;
   logic [BB-1:0]                       cnt_ff, cnt_in;
   logic [SB-1:0]                       step_ff, step_in;
   logic [mbps_pkg::COORD_BITS-1:0]     px_ff, px_in;
   logic [mbps_pkg::PY_BITS-1:0]        py_ff, py_in;
   logic [mbps_pkg::SQ_BITS-1:0]        sqx_ff, sqx_in;
   logic [mbps_pkg::SQ_BITS-1:0]        sqy_ff, sqy_in;
   logic [mbps_pkg::D2_BITS-1:0]        d2_ff, d2_in;
   logic [mbps_pkg::D2_BITS-1:0]        rem_ff, rem_in;
   logic [mbps_pkg::KBITS-1:0]          quo_ff, quo_in;
   logic [mbps_pkg::KBITS-1:0]          sv_ff, sv_in;
   logic [mbps_pkg::RT_BITS-1:0]        sres_ff, sres_in;
   logic [mbps_pkg::RT_BITS-1:0]        sbit_ff, sbit_in;
   logic [CB-1:0]                       accr_ff, accr_in;
   logic [CB-1:0]                       accg_ff, accg_in;
   logic [CB-1:0]                       accb_ff, accb_in;
   logic [CB-1:0]                       outr_ff, outr_in;
   logic [CB-1:0]                       outg_ff, outg_in;
   logic [CB-1:0]                       outb_ff, outb_in;
   logic                                outv_ff, outv_in;

   // combinational helpers
   logic                                last_ball, div_done, sqrt_done, out_free;
   logic [XB-1:0]                       cur_x, spd_x, np_x;
   logic [YB-1:0]                       cur_y, spd_y, np_y;
   logic                                flip_x, flip_y;
   logic signed [mbps_pkg::DX_BITS-1:0] dx, dy;
   logic signed [2*mbps_pkg::DX_BITS-1:0] prod_x, prod_y;
   logic [mbps_pkg::D2_BITS:0]          div_r2;
   logic                                div_ge;
   logic [mbps_pkg::RT_BITS-1:0]        sq_trial;
   logic                                sq_ge;
   logic [mbps_pkg::C_BITS-1:0]         contrib;

   assign last_ball = cnt_ff == BB'(NB - 1);
   assign div_done  = step_ff == SB'(mbps_pkg::KBITS - 1);
   assign sqrt_done = step_ff == SB'(mbps_pkg::SQ_STEPS - 1);
   assign out_free  = !outv_ff || rsp_bus.ready;

   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = outv_ff;
   assign rsp_bus.red   = outr_ff;
   assign rsp_bus.green = outg_ff;
   assign rsp_bus.blue  = outb_ff;

   // ball motion
   assign cur_x  = bx_ff[cnt_ff];
   assign cur_y  = by_ff[cnt_ff];
   assign spd_x  = XB'(speed_ff);
   assign spd_y  = YB'(speed_ff);
   assign np_x   = bdx_ff[cnt_ff] ? cur_x - spd_x : cur_x + spd_x;
   assign np_y   = bdy_ff[cnt_ff] ? cur_y - spd_y : cur_y + spd_y;
   assign flip_x = np_x[XB-1] || (np_x[XB-2:0] > (XB-1)'(width_ff));
   assign flip_y = np_y[YB-1] || (np_y[YB-2:0] > (YB-1)'(height_ff));

   // distance
   assign dx     = mbps_pkg::DX_BITS'($signed(cur_x)) - mbps_pkg::DX_BITS'($signed({1'b0, px_ff}));
   assign dy     = mbps_pkg::DX_BITS'($signed(cur_y)) - mbps_pkg::DX_BITS'($signed({2'b0, py_ff}));
   assign prod_x = dx * dx;
   assign prod_y = dy * dy;

   // one restoring division step
   assign div_r2 = {rem_ff, quo_ff[mbps_pkg::KBITS-1]};
   assign div_ge = div_r2 >= {1'b0, d2_ff};

   // one square root step
   assign sq_trial = sres_ff + sbit_ff;
   assign sq_ge    = mbps_pkg::RT_BITS'(sv_ff) >= sq_trial;

   // a ball right on the pixel gives full intensity
   assign contrib = (d2_ff == '0) ? mbps_pkg::C_BITS'(mbps_pkg::CHAN_MAX)
                                  : sres_ff[mbps_pkg::C_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbps_pkg::ST_IDLE: begin
            if (!fifo_stat.empty) begin
               if (pop_op.kind == mbps_pkg::REQ_FRAME) begin
                  state_in = mbps_pkg::ST_MOVE;
               end else if (pop_op.kind == mbps_pkg::REQ_PIXEL) begin
                  state_in = mbps_pkg::ST_DIST;
               end
            end
         end
         mbps_pkg::ST_MOVE: if (last_ball) state_in = mbps_pkg::ST_IDLE;
         mbps_pkg::ST_DIST: state_in = mbps_pkg::ST_SUM;
         mbps_pkg::ST_SUM:  state_in = mbps_pkg::ST_DIV;
         mbps_pkg::ST_DIV:  if (div_done) state_in = mbps_pkg::ST_SQRT;
         mbps_pkg::ST_SQRT: if (sqrt_done) state_in = mbps_pkg::ST_ACC;
         mbps_pkg::ST_ACC:  state_in = last_ball ? mbps_pkg::ST_OUT : mbps_pkg::ST_DIST;
         mbps_pkg::ST_OUT:  if (out_free) state_in = mbps_pkg::ST_IDLE;
         default:           state_in = mbps_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop       = 1'b0;
      width_in  = width_ff;
      height_in = height_ff;
      speed_in  = speed_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      bdx_in    = bdx_ff;
      bdy_in    = bdy_ff;
      bcol_in   = bcol_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      sqx_in    = sqx_ff;
      sqy_in    = sqy_ff;
      d2_in     = d2_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      sv_in     = sv_ff;
      sres_in   = sres_ff;
      sbit_in   = sbit_ff;
      accr_in   = accr_ff;
      accg_in   = accg_ff;
      accb_in   = accb_ff;
      outr_in   = outr_ff;
      outg_in   = outg_ff;
      outb_in   = outb_ff;
      outv_in   = outv_ff && !rsp_bus.ready;

      if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            mbps_pkg::CSR_FRAME_WIDTH:  width_in  = csr_bus.wdata;
            mbps_pkg::CSR_FRAME_HEIGHT: height_in = csr_bus.wdata[mbps_pkg::PY_BITS-1:0];
            mbps_pkg::CSR_BALL_SPEED:   speed_in  = csr_bus.wdata[mbps_pkg::SPEED_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         mbps_pkg::ST_IDLE: begin
            pop    = !fifo_stat.empty;
            cnt_in = '0;
            if (!fifo_stat.empty) begin
               if (pop_op.kind == mbps_pkg::REQ_LOAD) begin
                  bx_in[pop_op.ball]   = XB'(pop_op.x);
                  by_in[pop_op.ball]   = YB'(pop_op.y);
                  bdx_in[pop_op.ball]  = 1'b0;
                  bdy_in[pop_op.ball]  = 1'b0;
                  bcol_in[pop_op.ball] = pop_op.color;
               end
               px_in   = pop_op.x;
               py_in   = pop_op.y;
               accr_in = '0;
               accg_in = '0;
               accb_in = '0;
            end
         end
         mbps_pkg::ST_MOVE: begin
            bx_in[cnt_ff]  = np_x;
            by_in[cnt_ff]  = np_y;
            bdx_in[cnt_ff] = bdx_ff[cnt_ff] ^ flip_x;
            bdy_in[cnt_ff] = bdy_ff[cnt_ff] ^ flip_y;
            cnt_in         = cnt_ff + 1'b1;
         end
         mbps_pkg::ST_DIST: begin
            sqx_in = prod_x[mbps_pkg::SQ_BITS-1:0];
            sqy_in = prod_y[mbps_pkg::SQ_BITS-1:0];
         end
         mbps_pkg::ST_SUM: begin
            d2_in   = mbps_pkg::D2_BITS'(sqx_ff) + mbps_pkg::D2_BITS'(sqy_ff);
            rem_in  = '0;
            quo_in  = mbps_pkg::KBITS'(mbps_pkg::FULL_SCALE_SQ);
            step_in = '0;
         end
         mbps_pkg::ST_DIV: begin
            rem_in  = div_ge ? mbps_pkg::D2_BITS'(div_r2 - {1'b0, d2_ff})
                             : mbps_pkg::D2_BITS'(div_r2);
            quo_in  = {quo_ff[mbps_pkg::KBITS-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (div_done) begin
               sv_in   = {quo_ff[mbps_pkg::KBITS-2:0], div_ge};
               sres_in = '0;
               sbit_in = SBIT_INIT;
               step_in = '0;
            end
         end
         mbps_pkg::ST_SQRT: begin
            if (sq_ge) begin
               sv_in   = sv_ff - sq_trial[mbps_pkg::KBITS-1:0];
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            step_in = step_ff + 1'b1;
         end
         mbps_pkg::ST_ACC: begin
            case (bcol_ff[cnt_ff])
               mbps_pkg::COL_RED:   accr_in = sat_add(accr_ff, contrib);
               mbps_pkg::COL_GREEN: accg_in = sat_add(accg_ff, contrib);
               mbps_pkg::COL_BLUE:  accb_in = sat_add(accb_ff, contrib);
               default: begin
                  accr_in = sat_add(accr_ff, contrib);
                  accb_in = sat_add(accb_ff, contrib);
               end
            endcase
            cnt_in = cnt_ff + 1'b1;
         end
         mbps_pkg::ST_OUT: begin
            if (out_free) begin
               outr_in = accr_ff;
               outg_in = accg_ff;
               outb_in = accb_ff;
               outv_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mbps_pkg::ST_IDLE;
         outv_ff   <= 1'b0;
         width_ff  <= mbps_pkg::COORD_BITS'(mbps_pkg::WIDTH_RESET);
         height_ff <= mbps_pkg::PY_BITS'(mbps_pkg::HEIGHT_RESET);
         speed_ff  <= mbps_pkg::SPEED_BITS'(mbps_pkg::SPEED_RESET);
         cnt_ff    <= '0;
         step_ff   <= '0;
         for (int i = 0; i < NB; i++) begin
            bx_ff[i]   <= '0;
            by_ff[i]   <= '0;
            bdx_ff[i]  <= 1'b0;
            bdy_ff[i]  <= 1'b0;
            bcol_ff[i] <= mbps_pkg::COL_RED;
         end
      end else begin
         state_ff  <= state_in;
         outv_ff   <= outv_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         speed_ff  <= speed_in;
         cnt_ff    <= cnt_in;
         step_ff   <= step_in;
         bx_ff     <= bx_in;
         by_ff     <= by_in;
         bdx_ff    <= bdx_in;
         bdy_ff    <= bdy_in;
         bcol_ff   <= bcol_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      d2_ff   <= d2_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      sv_ff   <= sv_in;
      sres_ff <= sres_in;
      sbit_ff <= sbit_in;
      accr_ff <= accr_in;
      accg_ff <= accg_in;
      accb_ff <= accb_in;
      outr_ff <= outr_in;
      outg_ff <= outg_in;
      outb_ff <= outb_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/mbps_checker.sv =====
// ---------------------------------------------------------------------------
// mbps_checker: port level checks
// Watches the shader ports for response ordering and handshake slips.
// ---------------------------------------------------------------------------
`default_nettype none

module mbps_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [23:0] rsp_data
);

   logic [7:0] pend_ff, pend_in;
   logic       pix_xfer, rsp_xfer;

   assign pix_xfer = req_valid && req_ready && (req_type == mbps_pkg::REQ_PIXEL);
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (pix_xfer && !rsp_xfer) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_xfer && !pix_xfer) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // every response transfer answers an earlier pixel request
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> pend_ff != '0)
      else $error("response without pending pixel request");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response data changed while stalled");

endmodule

bind metaball_pixel_shader mbps_checker u_mbps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_type  (req_bus.req_type),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  ({rsp_bus.red, rsp_bus.green, rsp_bus.blue})
);

`default_nettype wire
